// ===== src/riff_wave_chunk_parser_top_defines.svh =====
// Assertion macros for the checker file of the WAVE chunk parser.
`ifndef RIFF_WAVE_CHUNK_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled at the rising edge, off while in reset.
`define RWCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled at the rising edge, off while in reset.
`define RWCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rwcp_pkg.sv =====
package rwcp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_PRE,
    PH_HDR,
    PH_BODY,
    PH_LOOK,
    PH_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    CK_OTHER,
    CK_FMT,
    CK_DATA
  } chunk_kind_t;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_PRE    = 3'd1;
  localparam logic [2:0] ST_NO_FMT     = 3'd2;
  localparam logic [2:0] ST_NO_DATA    = 3'd3;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd4;
  localparam logic [2:0] ST_BAD_DEPTH  = 3'd5;
  localparam logic [2:0] ST_ZERO_FIELD = 3'd6;

  // accepted format tags
  localparam logic [15:0] FMT_PCM = 16'h0001;
  localparam logic [15:0] FMT_EXT = 16'hfffe;

  // four-character codes, byte 0 in element 0
  localparam logic [3:0][7:0] TAG_RIFF = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] TAG_WAVE = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [3:0][7:0] TAG_FMT  = {8'h20, 8'h74, 8'h6d, 8'h66};
  localparam logic [3:0][7:0] TAG_DATA = {8'h61, 8'h74, 8'h61, 8'h64};

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  // decoded chunk header
  typedef struct packed {
    logic [31:0] size;
    logic        empty;
    chunk_kind_t kind;
  } hdr_info_t;

  // one result transaction
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_first;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
  } res_t;

endpackage

// ===== src/rwcp_ifs.sv =====
interface rwcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface rwcp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        payload_first;
  logic        done_res;
  logic [2:0]  status;
  logic [15:0] format_tag;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [15:0] sample_bits;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_first,
    output done_res, output status, output format_tag, output channel_count,
    output rate_hz, output sample_bits, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_first,
    input done_res, input status, input format_tag, input channel_count,
    input rate_hz, input sample_bits, output ready
  );
endinterface

// ===== src/rwcp_hdr_decode.sv =====
module rwcp_hdr_decode (
  input  logic [7:0][7:0]       hdr_bytes,
  output rwcp_pkg::hdr_info_t   info
);
  import rwcp_pkg::*;

  logic [31:0] size;
  logic        is_fmt;
  logic        is_data;

  // size field is little endian in bytes 4..7
  assign size    = hdr_bytes[7:4];
  assign is_fmt  = (hdr_bytes[3:0] == TAG_FMT) && (size >= FMT_MIN_SIZE);
  assign is_data = (hdr_bytes[3:0] == TAG_DATA);

  always_comb begin
    info.size  = size;
    info.empty = (size == 32'd0);
    if (is_fmt) begin
      info.kind = CK_FMT;
    end else if (is_data) begin
      info.kind = CK_DATA;
    end else begin
      info.kind = CK_OTHER;
    end
  end

endmodule

// ===== src/rwcp_core.sv =====
module rwcp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output rwcp_pkg::res_t res
);
  import rwcp_pkg::*;

  localparam logic [4:0] PRE_LAST  = 5'd11;
  localparam logic [4:0] HDR_LAST  = 5'd7;
  localparam logic [4:0] LOOK_LAST = 5'd8;
  localparam logic [4:0] FMT_LEN   = 5'd16;
  localparam logic [4:0] FMT_LAST  = 5'd15;
  localparam logic [4:0] FMT_B14   = 5'd14;
  localparam logic [4:0] FMT_LOW   = 5'd8;
  localparam logic [4:0] PRE_WAVE  = 5'd8;
  localparam logic [4:0] PRE_SIZE  = 5'd4;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7e;
  localparam int SEEN_PRE  = 0;
  localparam int SEEN_FMT  = 1;
  localparam int SEEN_DATA = 2;

  phase_t          phase_r, phase_nxt;
  logic [4:0]      pc_r, pc_nxt;
  logic [31:0]     left_r, left_nxt;
  logic            odd_r, odd_nxt;
  chunk_kind_t     kind_r, kind_nxt;
  logic [8:0][7:0] look_r, look_nxt;
  logic [7:0][7:0] shadow_r, shadow_nxt;
  logic [7:0]      s14_r, s14_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [15:0]     chan_r, chan_nxt;
  logic [31:0]     rate_r, rate_nxt;
  logic [15:0]     depth_r, depth_nxt;
  logic [2:0]      seen_r, seen_nxt;

  logic            look_final;
  logic            padded;
  logic [7:0][7:0] hdr_bytes;
  hdr_info_t       hdr;
  logic            pay_valid;
  logic [7:0]      pay_byte;
  logic            pay_first;
  logic [2:0]      status;

  assign look_final = (phase_r == PH_LOOK) && (pc_r == LOOK_LAST);

  // padded position holds printable id bytes
  always_comb begin
    padded = 1'b1;
    for (int i = 1; i <= 4; i++) begin
      if (!(look_r[i] inside {[PRINT_LO:PRINT_HI]})) begin
        padded = 1'b0;
      end
    end
  end

  // header byte window: padded, unpadded, or plain header fill
  always_comb begin
    if (look_final && padded) begin
      hdr_bytes = {in_byte, look_r[7:1]};
    end else if (look_final) begin
      hdr_bytes = look_r[7:0];
    end else begin
      hdr_bytes = {in_byte, look_r[6:0]};
    end
  end

  rwcp_hdr_decode u_hdr_decode (
    .hdr_bytes (hdr_bytes),
    .info      (hdr)
  );

  always_comb begin
    logic hdr_parse;
    logic body_go;
    phase_nxt  = phase_r;
    pc_nxt     = pc_r;
    left_nxt   = left_r;
    odd_nxt    = odd_r;
    kind_nxt   = kind_r;
    look_nxt   = look_r;
    shadow_nxt = shadow_r;
    s14_nxt    = s14_r;
    tag_nxt    = tag_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    depth_nxt  = depth_r;
    seen_nxt   = seen_r;
    pay_valid  = 1'b0;
    pay_byte   = 8'd0;
    pay_first  = 1'b0;
    hdr_parse  = 1'b0;
    body_go    = 1'b0;

    case (phase_r)
      PH_PRE: begin
        if (((pc_r < PRE_SIZE) && (in_byte != TAG_RIFF[pc_r[1:0]])) ||
            ((pc_r >= PRE_WAVE) && (in_byte != TAG_WAVE[pc_r[1:0]]))) begin
          phase_nxt = PH_DEAD;
        end else if (pc_r == PRE_LAST) begin
          seen_nxt[SEEN_PRE] = 1'b1;
          phase_nxt          = PH_HDR;
          pc_nxt             = 5'd0;
        end else begin
          pc_nxt = pc_r + 5'd1;
        end
      end
      PH_HDR: begin
        look_nxt[{1'b0, pc_r[2:0]}] = in_byte;
        pc_nxt                      = pc_r + 5'd1;
        hdr_parse                   = (pc_r == HDR_LAST);
      end
      PH_BODY: begin
        body_go = 1'b1;
      end
      PH_LOOK: begin
        look_nxt[pc_r[3:0]] = in_byte;
        pc_nxt              = pc_r + 5'd1;
      end
      default: begin
      end
    endcase

    if (hdr_parse || look_final) begin
      left_nxt = hdr.size;
      odd_nxt  = hdr.size[0];
      kind_nxt = hdr.kind;
      if (hdr.kind == CK_DATA) begin
        seen_nxt[SEEN_DATA] = 1'b1;
      end
      pc_nxt    = 5'd0;
      phase_nxt = hdr.empty ? PH_HDR : PH_BODY;
    end

    // unpadded pick: the ninth window byte belongs to the new chunk
    if (look_final && !padded) begin
      if (hdr.empty) begin
        look_nxt[0] = in_byte;
        pc_nxt      = 5'd1;
      end else begin
        body_go = 1'b1;
      end
    end

    if (body_go) begin
      case (kind_nxt)
        CK_DATA: begin
          pay_valid = 1'b1;
          pay_byte  = in_byte;
          pay_first = (pc_nxt == 5'd0);
        end
        CK_FMT: begin
          if (pc_nxt < FMT_LOW) begin
            shadow_nxt[pc_nxt[2:0]] = in_byte;
          end
          if (pc_nxt == FMT_B14) begin
            s14_nxt = in_byte;
          end
          if (pc_nxt == FMT_LAST) begin
            tag_nxt            = shadow_r[1:0];
            chan_nxt           = shadow_r[3:2];
            rate_nxt           = shadow_r[7:4];
            depth_nxt          = {in_byte, s14_r};
            seen_nxt[SEEN_FMT] = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (pc_nxt < FMT_LEN) begin
        pc_nxt = pc_nxt + 5'd1;
      end
      if (left_nxt == 32'd1) begin
        phase_nxt = odd_nxt ? PH_LOOK : PH_HDR;
        pc_nxt    = 5'd0;
      end
      left_nxt = left_nxt - 32'd1;
    end
  end

  // first failing check wins
  always_comb begin
    if (!in_last) begin
      status = ST_OK;
    end else if (!seen_nxt[SEEN_PRE]) begin
      status = ST_BAD_PRE;
    end else if (!seen_nxt[SEEN_FMT]) begin
      status = ST_NO_FMT;
    end else if (!seen_nxt[SEEN_DATA]) begin
      status = ST_NO_DATA;
    end else if (!(tag_nxt inside {FMT_PCM, FMT_EXT})) begin
      status = ST_BAD_FORMAT;
    end else if (!(depth_nxt inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
      status = ST_BAD_DEPTH;
    end else if ((chan_nxt == 16'd0) || (rate_nxt == 32'd0)) begin
      status = ST_ZERO_FIELD;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res.payload_valid = pay_valid;
    res.payload_byte  = pay_byte;
    res.payload_first = pay_first;
    res.done_res      = in_last;
    res.status        = status;
    res.format_tag    = tag_nxt;
    res.channel_count = chan_nxt;
    res.rate_hz       = rate_nxt;
    res.sample_bits   = depth_nxt;
  end

  // the last byte of a file returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && in_last)) begin
      phase_r <= PH_PRE;
      pc_r    <= 5'd0;
      left_r  <= 32'd0;
      odd_r   <= 1'b0;
      kind_r  <= CK_OTHER;
      tag_r   <= 16'd0;
      chan_r  <= 16'd0;
      rate_r  <= 32'd0;
      depth_r <= 16'd0;
      seen_r  <= 3'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pc_r    <= pc_nxt;
      left_r  <= left_nxt;
      odd_r   <= odd_nxt;
      kind_r  <= kind_nxt;
      tag_r   <= tag_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      depth_r <= depth_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // window and fmt bytes are always written before they are read
  always_ff @(posedge clk) begin
    if (step_en) begin
      look_r   <= look_nxt;
      shadow_r <= shadow_nxt;
      s14_r    <= s14_nxt;
    end
  end

endmodule

// ===== src/riff_wave_chunk_parser_top.sv =====
// RIFF/WAVE chunk parser. Feed a WAVE file one byte per input transaction,
// with last set on the final byte; every input transaction yields exactly one
// result transaction. The block checks the RIFF/WAVE preamble, walks the
// little-endian chunks, latches format tag, channels, rate and bits per
// sample from each 'fmt ' chunk of at least 16 bytes (the last one wins) and
// passes every 'data' body byte out with payload_valid, marking the first
// byte of each data chunk with payload_first. After an odd-sized chunk the
// next header is picked by a nine-byte lookahead: padded if the four id bytes
// at the padded position are printable ASCII, unpadded otherwise. The result
// for the last byte carries done_res and the final status (0 ok, 1 bad
// preamble, 2 no fmt, 3 no data, 4 format tag, 5 bit depth, 6 zero channels
// or rate); after it the parser starts over for a new file. Throughput is one
// byte per clock while the consumer takes results: each byte sits in an input
// register, is processed by the state update of the parser core, and lands
// in the result register. in_if.ready stays high while the input register is
// empty or can move on, which lets a result wait for its consumer while the
// next byte is taken in.
module riff_wave_chunk_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  rwcp_in_if.sink           in_if,
  rwcp_out_if.source        out_if
);
  import rwcp_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic       out_valid_r;
  res_t       out_res_r;

  res_t       step_res;
  logic       step_en;

  // The held byte moves on whenever the result register is free or is being
  // emptied in this cycle.
  assign step_en     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.in_byte;
      s1_last_r <= in_if.last;
    end
  end

  // Parser state and the per-byte update live in the core; it advances only
  // when a byte leaves the input register.
  rwcp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.payload_valid = out_res_r.payload_valid;
  assign out_if.payload_byte  = out_res_r.payload_byte;
  assign out_if.payload_first = out_res_r.payload_first;
  assign out_if.done_res      = out_res_r.done_res;
  assign out_if.status        = out_res_r.status;
  assign out_if.format_tag    = out_res_r.format_tag;
  assign out_if.channel_count = out_res_r.channel_count;
  assign out_if.rate_hz       = out_res_r.rate_hz;
  assign out_if.sample_bits   = out_res_r.sample_bits;

endmodule

// ===== src/rwcp_checker.sv =====
`include "riff_wave_chunk_parser_top_defines.svh"

module rwcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic        payload_first,
  input logic        done_res,
  input logic [2:0]  status,
  input logic [15:0] format_tag,
  input logic [15:0] channel_count,
  input logic [31:0] rate_hz
);
  import rwcp_pkg::*;

  // stalled result holds
  `RWCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(status) && $stable(rate_hz), "result changed while stalled")

  // no data byte: payload fields are zero
  `RWCP_ASSERT_NOW(a_pay_idle, clk, rst_n, out_valid && !payload_valid, (payload_byte == 8'd0) && !payload_first, "payload fields set without data byte")

  // status only reported on the last byte
  `RWCP_ASSERT_NOW(a_status_last, clk, rst_n, out_valid && !done_res, status == ST_OK, "status set before last byte")

  // ok status needs a usable format
  `RWCP_ASSERT_NOW(a_ok_format, clk, rst_n, out_valid && done_res && (status == ST_OK), ((format_tag == FMT_PCM) || (format_tag == FMT_EXT)) && (channel_count != 16'd0) && (rate_hz != 32'd0), "ok status with unusable format")

endmodule

bind riff_wave_chunk_parser_top rwcp_checker u_rwcp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .payload_valid (out_if.payload_valid),
  .payload_byte  (out_if.payload_byte),
  .payload_first (out_if.payload_first),
  .done_res      (out_if.done_res),
  .status        (out_if.status),
  .format_tag    (out_if.format_tag),
  .channel_count (out_if.channel_count),
  .rate_hz       (out_if.rate_hz)
);

// ===== tb/riff_wave_chunk_parser_top_tb.sv =====
module riff_wave_chunk_parser_top_tb;
  import rwcp_pkg::*;

  // Tracks the parser state byte by byte and holds the results still due
  class wave_parse_tracker;
    phase_t      ph;
    chunk_kind_t kind;
    logic [7:0]  window [9];
    logic [7:0]  fmt_bytes [16];
    logic [31:0] step_cnt;
    logic [31:0] bytes_left;
    logic        odd_size;
    logic        got_pre, got_fmt, got_data;
    logic [15:0] tag_q, chan_q, depth_q;
    logic [31:0] rate_q;
    res_t        cur;
    res_t        results_due [$];
    int          n_errors, n_results, n_payload, n_files;
    bit [6:0]    status_seen;

    function new();
      n_errors = 0;
      n_results = 0;
      n_payload = 0;
      n_files = 0;
      status_seen = '0;
      clear();
    endfunction

    function void clear();
      ph = PH_PRE;
      kind = CK_OTHER;
      foreach (window[i]) window[i] = '0;
      foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
      step_cnt = '0;
      bytes_left = '0;
      odd_size = 1'b0;
      got_pre = 1'b0;
      got_fmt = 1'b0;
      got_data = 1'b0;
      tag_q = '0;
      chan_q = '0;
      depth_q = '0;
      rate_q = '0;
    endfunction

    function void end_body();
      ph = odd_size ? PH_LOOK : PH_HDR;
      step_cnt = '0;
    endfunction

    function void take_header(int unsigned off);
      logic [31:0] sz;
      bit          is_fmt, is_data;
      sz = {window[off+7], window[off+6], window[off+5], window[off+4]};
      is_fmt = 1'b1;
      is_data = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (window[off+i] != TAG_FMT[i]) is_fmt = 1'b0;
        if (window[off+i] != TAG_DATA[i]) is_data = 1'b0;
      end
      bytes_left = sz;
      odd_size = sz[0];
      if (is_fmt && sz >= FMT_MIN_SIZE) begin
        kind = CK_FMT;
      end else if (is_data) begin
        kind = CK_DATA;
        got_data = 1'b1;
      end else begin
        kind = CK_OTHER;
      end
      ph = PH_BODY;
      step_cnt = '0;
      if (sz == 0) end_body();
    endfunction

    function void feed_byte(logic [7:0] b);
      if (ph == PH_HDR) begin
        window[{1'b0, step_cnt[2:0]}] = b;
        step_cnt++;
        if (step_cnt >= 8) take_header(0);
        return;
      end
      if (ph != PH_BODY) return;
      if (kind == CK_DATA) begin
        cur.payload_valid = 1'b1;
        cur.payload_byte = b;
        cur.payload_first = (step_cnt == 0);
      end else if (kind == CK_FMT && step_cnt < 16) begin
        fmt_bytes[step_cnt[3:0]] = b;
        if (step_cnt == 15) begin
          tag_q = {fmt_bytes[1], fmt_bytes[0]};
          chan_q = {fmt_bytes[3], fmt_bytes[2]};
          rate_q = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
          depth_q = {fmt_bytes[15], fmt_bytes[14]};
          got_fmt = 1'b1;
        end
      end
      if (step_cnt < 16) step_cnt++;
      bytes_left--;
      if (bytes_left == 0) end_body();
    endfunction

    function bit id_printable();
      for (int i = 1; i < 5; i++)
        if (window[i] < 8'h20 || window[i] > 8'h7e) return 1'b0;
      return 1'b1;
    endfunction

    function logic [2:0] final_code();
      if (!got_pre) return ST_BAD_PRE;
      if (!got_fmt) return ST_NO_FMT;
      if (!got_data) return ST_NO_DATA;
      if (tag_q != FMT_PCM && tag_q != FMT_EXT) return ST_BAD_FORMAT;
      if (depth_q != 16'd8 && depth_q != 16'd16 && depth_q != 16'd24 && depth_q != 16'd32)
        return ST_BAD_DEPTH;
      if (chan_q == 0 || rate_q == 0) return ST_ZERO_FIELD;
      return ST_OK;
    endfunction

    // one accepted input byte -> one result due
    function void note_input(logic [7:0] b, logic lst);
      logic [7:0] carry;
      cur = '0;
      case (ph)
        PH_PRE: begin
          if ((step_cnt < 4 && b != TAG_RIFF[step_cnt[1:0]]) ||
              (step_cnt >= 8 && step_cnt < 12 && b != TAG_WAVE[step_cnt[1:0]])) begin
            ph = PH_DEAD;
          end else begin
            step_cnt++;
            if (step_cnt >= 12) begin
              got_pre = 1'b1;
              ph = PH_HDR;
              step_cnt = '0;
            end
          end
        end
        PH_LOOK: begin
          window[step_cnt < 9 ? step_cnt : 8] = b;
          step_cnt++;
          if (step_cnt >= 9) begin
            if (id_printable()) begin
              take_header(1);
            end else begin
              // unpadded: header at 0..7, byte 8 belongs to the body
              carry = window[8];
              take_header(0);
              feed_byte(carry);
            end
          end
        end
        default: feed_byte(b);
      endcase
      cur.done_res = lst;
      cur.status = lst ? final_code() : ST_OK;
      cur.format_tag = tag_q;
      cur.channel_count = chan_q;
      cur.rate_hz = rate_q;
      cur.sample_bits = depth_q;
      results_due.push_back(cur);
      if (lst) begin
        clear();
        n_files++;
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        n_errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing due, expected none, actual %p", $time, got);
        return;
      end
      want = results_due.pop_front();
      n_results++;
      if (want.payload_valid) n_payload++;
      if (want.done_res) status_seen[want.status] = 1'b1;
      cmp_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
      cmp_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      cmp_field("payload_first", 32'(want.payload_first), 32'(got.payload_first));
      cmp_field("done_res", 32'(want.done_res), 32'(got.done_res));
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("format_tag", 32'(want.format_tag), 32'(got.format_tag));
      cmp_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
      cmp_field("rate_hz", want.rate_hz, got.rate_hz);
      cmp_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rwcp_in_if  in_if ();
  rwcp_out_if out_if ();

  riff_wave_chunk_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  wave_parse_tracker tracker = new();

  // idle / stall knobs, percent of cycles
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  // long receiver hold-off, counted down by the sink process
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;

  always #10 clk = ~clk;

  // hard stop in case the handshake hangs
  initial begin
    #4000000;
    $display("%0t: timeout, %0d results still due", $time, tracker.results_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // result side: ready changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk) begin
    res_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.payload_valid = out_if.payload_valid;
      seen.payload_byte = out_if.payload_byte;
      seen.payload_first = out_if.payload_first;
      seen.done_res = out_if.done_res;
      seen.status = out_if.status;
      seen.format_tag = out_if.format_tag;
      seen.channel_count = out_if.channel_count;
      seen.rate_hz = out_if.rate_hz;
      seen.sample_bits = out_if.sample_bits;
      tracker.check_result(seen);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.last <= lst;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    tracker.note_input(b, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  function automatic void put_le32(ref logic [7:0] q[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_tag(ref logic [7:0] q[$], input logic [3:0][7:0] id);
    for (int i = 0; i < 4; i++) q.push_back(id[i]);
  endfunction

  // header, body and (usually) the pad byte after an odd size
  function automatic void put_chunk(ref logic [7:0] q[$], input logic [3:0][7:0] id,
                                    input logic [31:0] sz, input logic [7:0] body[$]);
    put_tag(q, id);
    put_le32(q, sz);
    foreach (body[i]) q.push_back(body[i]);
    if (sz[0] && body.size() == sz && $urandom_range(0, 4) != 0)
      q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
  endfunction

  function automatic void put_fmt(ref logic [7:0] q[$]);
    logic [7:0]  body [$];
    logic [7:0]  head [16];
    logic [31:0] sz, rate;
    logic [15:0] tag, chans, bits;
    int unsigned r;
    r = $urandom_range(0, 9);
    sz = r < 5 ? 32'd16 : r < 7 ? 32'd18 : r < 8 ? 32'd17 : r < 9 ? 32'd40
       : 32'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    tag = r < 6 ? FMT_PCM : r < 8 ? FMT_EXT : r < 9 ? 16'h0000 : 16'($urandom);
    r = $urandom_range(0, 9);
    chans = r < 8 ? 16'($urandom_range(1, 8)) : r < 9 ? 16'h0000 : 16'hffff;
    r = $urandom_range(0, 9);
    rate = r < 3 ? 32'd44100 : r < 5 ? 32'd48000 : r < 6 ? 32'hffffffff
         : r < 9 ? 32'($urandom) : 32'd0;
    r = $urandom_range(0, 19);
    bits = r < 17 ? 16'(8 * $urandom_range(1, 4)) : r < 18 ? 16'h0000 : 16'($urandom);
    {head[1], head[0]} = tag;
    {head[3], head[2]} = chans;
    {head[7], head[6], head[5], head[4]} = rate;
    for (int i = 8; i < 14; i++) head[i] = 8'($urandom);
    {head[15], head[14]} = bits;
    for (int i = 0; i < sz; i++) body.push_back(i < 16 ? head[i] : 8'($urandom));
    put_chunk(q, TAG_FMT, sz, body);
  endfunction

  // returns 1 when the chunk never ends (huge size), so the file stops there
  function automatic bit put_data(ref logic [7:0] q[$]);
    logic [7:0]  body [$];
    logic [31:0] sz;
    int unsigned r, n;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
      put_chunk(q, TAG_DATA, 32'hffffffff, body);
      return 1'b1;
    end
    sz = r < 3 ? 32'd0 : r < 17 ? 32'($urandom_range(1, 12)) : 32'($urandom_range(13, 40));
    for (int i = 0; i < sz; i++) body.push_back(8'($urandom));
    put_chunk(q, TAG_DATA, sz, body);
    return 1'b0;
  endfunction

  function automatic void put_other(ref logic [7:0] q[$]);
    logic [7:0]       body [$];
    logic [3:0][7:0]  id;
    logic [31:0]      sz;
    int unsigned      r;
    r = $urandom_range(0, 9);
    if (r < 3) id = {8'h54, 8'h53, 8'h49, 8'h4c};       // LIST
    else if (r < 5) id = {8'h74, 8'h63, 8'h61, 8'h66};  // fact
    else if (r < 6) id = {8'h20, 8'h74, 8'h6d, 8'h66};  // fmt, but too short below
    else if (r < 9) for (int i = 0; i < 4; i++) id[i] = 8'($urandom_range(8'h20, 8'h7e));
    else id = $urandom;                                 // id outside printable range
    sz = 32'($urandom_range(0, 9));
    for (int i = 0; i < sz; i++) body.push_back(8'($urandom));
    put_chunk(q, id, sz, body);
  endfunction

  // one random file: mostly well formed, some noise and broken preambles
  function automatic void make_wave_file(ref logic [7:0] q[$]);
    int unsigned r, n, cut;
    bit          std_order, open_end;
    logic [7:0]  b;
    q.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      n = $urandom_range(1, 20);
      if ($urandom_range(0, 1)) put_tag(q, TAG_RIFF);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    end else if (r < 12) begin
      put_tag(q, TAG_RIFF);
      put_le32(q, $urandom);
      put_tag(q, TAG_WAVE);
      // spoil one preamble byte
      cut = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      b = 8'($urandom);
      if (b == q[cut]) b = ~b;
      q[cut] = b;
      put_fmt(q);
      void'(put_data(q));
    end else begin
      put_tag(q, TAG_RIFF);
      put_le32(q, $urandom);
      put_tag(q, TAG_WAVE);
      std_order = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 4);
      open_end = 1'b0;
      for (int c = 0; c < n && !open_end; c++) begin
        if (std_order && c == 0) put_fmt(q);
        else if (std_order && c == 1) open_end = put_data(q);
        else begin
          r = $urandom_range(0, 2);
          if (r == 0) put_fmt(q);
          else if (r == 1) open_end = put_data(q);
          else put_other(q);
        end
      end
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, q.size());
        while (q.size() > cut) void'(q.pop_back());
      end
    end
  endfunction

  initial begin
    logic [7:0]  file_q [$];
    int unsigned phase_bytes;

    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single byte file, all ones
    file_q = '{8'hff};
    send_file(file_q);
    // preamble broken in its fourth byte; the rest is ignored
    file_q = '{8'h52, 8'h49, 8'h46, 8'h00, 8'h55};
    send_file(file_q);
    // good preamble plus an empty data chunk, no fmt
    file_q.delete();
    put_tag(file_q, TAG_RIFF);
    put_le32(file_q, 32'hffffffff);
    put_tag(file_q, TAG_WAVE);
    put_tag(file_q, TAG_DATA);
    put_le32(file_q, 32'd0);
    send_file(file_q);

    // random files over four handshake phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          hold_left = 300;  // back-pressure until the input side stalls
        end
        1: begin
          src_idle_pct = 86;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 86;
        end
        default: begin
          src_idle_pct = 18;
          sink_stall_pct = 18;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 280) begin
        make_wave_file(file_q);
        send_file(file_q);
        phase_bytes += file_q.size();
      end
    end
    in_if.valid <= 1'b0;

    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d files, %0d bytes in, %0d results checked, %0d payload bytes",
             tracker.n_files, bytes_sent, tracker.n_results, tracker.n_payload);
    $display("End status codes seen (bit per code, 6..0): %b", tracker.status_seen);
    if (tracker.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
